[hw/rtl/lcabl_pkg.sv]
// shared types and constants of the binary lifting lca core
`default_nettype none

package lcabl_pkg;

    // node ids as they travel on the stream ports; depths use the same type
    localparam int NODE_W = 10;
    typedef logic [NODE_W-1:0] t_node;

    localparam t_node DEPTH_MAX = '1;

    // default tree size
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;

    // stream widths, tdata in whole bytes
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;

    // operation codes carried in the input tuser
    localparam logic [S_TUSER_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [S_TUSER_W-1:0] OP_QUERY = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/lca_binary_lifting_core.sv]
// lowest common ancestor engine over a binary lifting table, top level
`default_nettype none

// Lowest common ancestor engine for a rooted tree. A load transfer (tuser =
// load) names a node and its parent (parent 0 marks a root); parents must be
// loaded before their children. The core stores the node's depth and fills
// its row of the 2^k ancestor table, one level per cycle, and gives no
// result. A query transfer names two nodes and yields one result transfer
// with their lowest common ancestor, 0 meaning none. A query runs three
// passes over the table levels through a single ancestor memory read port
// and a single depth memory read port; each level of a pass is a read, then
// a dependent read and compare. Node ids at or above NODES read as having no
// ancestors and depth zero; loads of them are dropped. The memories are not
// cleared after reset: querying a node that was never loaded gives an
// undefined answer. The input is taken only while the core is idle; a
// finished result waits in the output register, so the next item can be
// accepted before the result is taken.
module lca_binary_lifting_core #(
    parameter int NODES  = lcabl_pkg::NODES_DEF,
    parameter int LEVELS = lcabl_pkg::LEVELS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [lcabl_pkg::S_TDATA_W-1:0] s_axis_tdata,  // node_a, node_b, zero pad
    input  wire  [lcabl_pkg::S_TUSER_W-1:0] s_axis_tuser,  // operation
    // result stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [lcabl_pkg::M_TDATA_W-1:0] m_axis_tdata   // ancestor_node, zero pad
);
    import lcabl_pkg::*;

    // table geometry: row of a node is {node, level}
    localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = NODES << LVL_W;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;   // waiting for an input transfer
    localparam logic [3:0] S_LDEP = 4'd1;   // load: parent depth back, write depth and level 0
    localparam logic [3:0] S_LROW = 4'd2;   // load: one ancestor level per cycle
    localparam logic [3:0] S_QDX  = 4'd3;   // query: depth of x back
    localparam logic [3:0] S_QDY  = 4'd4;   // query: depth of y back
    localparam logic [3:0] S_P1A  = 4'd5;   // lift x: ancestor back
    localparam logic [3:0] S_P1B  = 4'd6;   // lift x: its depth back, compare
    localparam logic [3:0] S_P2A  = 4'd7;   // lift y: ancestor back
    localparam logic [3:0] S_P2B  = 4'd8;   // lift y: its depth back, compare
    localparam logic [3:0] S_P3A  = 4'd9;   // joint climb: ancestor of x back
    localparam logic [3:0] S_P3B  = 4'd10;  // joint climb: ancestor of y back, compare
    localparam logic [3:0] S_QFIN = 4'd11;  // parent of x back, that is the answer
    localparam logic [3:0] S_DONE = 4'd12;  // answer waits for the output register

    // node that has a table row and a depth entry
    function automatic logic node_ok(input t_node n);
        node_ok = (n != '0) && (32'(n) < NODES);
    endfunction

    // unpacked input fields
    t_node in_a;
    t_node in_b;
    assign in_a = s_axis_tdata[NODE_W-1:0];
    assign in_b = s_axis_tdata[2*NODE_W-1:NODE_W];

    // control state
    logic [3:0]       r_state, n_state;
    logic             r_out_valid;

    // working registers: x/y hold the query nodes, or the loaded node and
    // the running ancestor during a load
    t_node            r_x, n_x;
    t_node            r_y, n_y;
    t_node            r_t, n_t;
    t_node            r_dx, n_dx;
    t_node            r_dy, n_dy;
    t_node            r_res, n_res;
    logic [LVL_W-1:0] r_i, n_i;
    t_node            r_out_data;

    // memories with registered read data and an in-range flag beside it
    t_node            r_anc_mem [0:ANC_DEPTH-1];
    t_node            r_dep_mem [0:NODES-1];
    t_node            r_anc_q;
    t_node            r_dep_q;
    logic             r_anc_ok;
    logic             r_dep_ok;

    // memory port controls
    t_node            anc_rn;
    logic [LVL_W-1:0] anc_rl;
    logic             anc_we;
    t_node            anc_wn;
    logic [LVL_W-1:0] anc_wl;
    t_node            anc_wd;
    t_node            dep_rn;
    logic             dep_we;
    t_node            dep_wd;

    // read values with out-of-range nodes forced to zero
    t_node            anc_val;
    t_node            dep_val;
    assign anc_val = r_anc_ok ? r_anc_q : '0;
    assign dep_val = r_dep_ok ? r_dep_q : '0;

    // shared compare and next-value logic
    logic [NODE_W:0]  dep_inc;
    t_node            dep_new;
    t_node            row_next;
    logic             take_x;
    logic             take_y;
    t_node            x_lift;
    t_node            y_lift;
    logic             climb;

    always_comb begin
        dep_inc  = {1'b0, dep_val} + {{NODE_W{1'b0}}, 1'b1};
        // parent 0 means root; depth saturates at the field maximum
        if (r_y == '0) begin
            dep_new = '0;
        end else if (dep_inc[NODE_W]) begin
            dep_new = DEPTH_MAX;
        end else begin
            dep_new = dep_inc[NODE_W-1:0];
        end
        // a self parent reads back the entry written in the same cycle
        row_next = (r_y == r_x) ? r_y : anc_val;
        take_x   = (r_t != '0) && (dep_val >= r_dy);
        take_y   = (r_t != '0) && (dep_val >= r_dx);
        x_lift   = take_x ? r_t : r_x;
        y_lift   = take_y ? r_t : r_y;
        climb    = (r_t != anc_val);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_data);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_t     = r_t;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_res   = r_res;
        n_i     = r_i;
        anc_rn  = r_x;
        anc_rl  = r_i;
        anc_we  = 1'b0;
        anc_wn  = r_x;
        anc_wl  = r_i;
        anc_wd  = r_y;
        dep_rn  = r_t;
        dep_we  = 1'b0;
        dep_wd  = dep_new;
        case (r_state)
            S_IDLE: begin
                n_x    = in_a;
                n_y    = in_b;
                dep_rn = (s_axis_tuser == OP_QUERY) ? in_a : in_b;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_QUERY) begin
                        n_state = S_QDX;
                    end else if (node_ok(in_a)) begin
                        n_state = S_LDEP;
                    end
                end
            end
            S_LDEP: begin
                dep_we  = 1'b1;
                anc_we  = 1'b1;
                anc_wl  = '0;
                anc_rn  = r_y;
                anc_rl  = '0;
                n_i     = '0;
                n_state = S_LROW;
            end
            S_LROW: begin
                if (r_i == LVL_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_i    = r_i + 1'b1;
                    n_y    = row_next;
                    anc_we = 1'b1;
                    anc_wl = r_i + 1'b1;
                    anc_wd = row_next;
                    anc_rn = row_next;
                    anc_rl = r_i + 1'b1;
                end
            end
            S_QDX: begin
                n_dx    = dep_val;
                dep_rn  = r_y;
                n_state = S_QDY;
            end
            S_QDY: begin
                n_dy    = dep_val;
                n_i     = LVL_LAST;
                anc_rn  = r_x;
                anc_rl  = LVL_LAST;
                n_state = S_P1A;
            end
            S_P1A: begin
                n_t     = anc_val;
                dep_rn  = anc_val;
                n_state = S_P1B;
            end
            S_P1B: begin
                n_x = x_lift;
                if (take_x) begin
                    n_dx = dep_val;
                end
                if (r_i == '0) begin
                    n_i     = LVL_LAST;
                    anc_rn  = r_y;
                    anc_rl  = LVL_LAST;
                    n_state = S_P2A;
                end else begin
                    n_i     = r_i - 1'b1;
                    anc_rn  = x_lift;
                    anc_rl  = r_i - 1'b1;
                    n_state = S_P1A;
                end
            end
            S_P2A: begin
                n_t     = anc_val;
                dep_rn  = anc_val;
                n_state = S_P2B;
            end
            S_P2B: begin
                n_y = y_lift;
                if (r_i == '0) begin
                    if (r_x == y_lift) begin
                        n_res   = r_x;
                        n_state = S_DONE;
                    end else begin
                        n_i     = LVL_LAST;
                        anc_rn  = r_x;
                        anc_rl  = LVL_LAST;
                        n_state = S_P3A;
                    end
                end else begin
                    n_i     = r_i - 1'b1;
                    anc_rn  = y_lift;
                    anc_rl  = r_i - 1'b1;
                    n_state = S_P2A;
                end
            end
            S_P3A: begin
                n_t     = anc_val;
                anc_rn  = r_y;
                anc_rl  = r_i;
                n_state = S_P3B;
            end
            S_P3B: begin
                // both climb only while their ancestors still differ
                if (climb) begin
                    n_x = r_t;
                    n_y = anc_val;
                end
                anc_rn = climb ? r_t : r_x;
                if (r_i == '0) begin
                    anc_rl  = '0;
                    n_state = S_QFIN;
                end else begin
                    n_i     = r_i - 1'b1;
                    anc_rl  = r_i - 1'b1;
                    n_state = S_P3A;
                end
            end
            S_QFIN: begin
                n_res   = anc_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_t   <= n_t;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_res <= n_res;
        r_i   <= n_i;
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= r_res;
        end
    end

    // ancestor table, one write and one read port
    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anc_mem[{NODE_AW'(anc_wn), anc_wl}] <= anc_wd;
        end
        r_anc_q  <= r_anc_mem[{NODE_AW'(anc_rn), anc_rl}];
        r_anc_ok <= node_ok(anc_rn);
    end

    // depth table, one write and one read port
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_mem[NODE_AW'(r_x)] <= dep_wd;
        end
        r_dep_q  <= r_dep_mem[NODE_AW'(dep_rn)];
        r_dep_ok <= node_ok(dep_rn);
    end

endmodule

`default_nettype wire
